// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// Depends on nothing; every macro expects a clock named clk and a reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/chm_pkg.sv -----
// Shared types and constants for the counted hash multiset.
// Depends on nothing; every file of the block but assert_macros.svh imports it.
package chm_pkg;

	localparam int KEY_W = 64;
	localparam int COUNT_OUT_W = 32;
	localparam int TOTAL_W = 7;
	localparam int MAX_RESULTS = 44;

	localparam logic [31:0] MIX_C1 = 32'hed5ad4bb;
	localparam logic [31:0] MIX_C2 = 32'hac4c1b51;
	localparam int MIX_SH1 = 17;
	localparam int MIX_SH2 = 11;
	localparam int MIX_SH3 = 15;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DROP   = 2'd1,
		ACT_FLUSH  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_NEW         = 4'd0,
		ST_INCREMENTED = 4'd1,
		ST_DECREMENTED = 4'd2,
		ST_REMOVED     = 4'd3,
		ST_ABSENT      = 4'd4,
		ST_FULL        = 4'd5,
		ST_FLUSHED     = 4'd6,
		ST_FLUSH_EMPTY = 4'd7,
		ST_SATURATED   = 4'd8,
		ST_INVALID     = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_LIVE  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_t;

endpackage

// ----- hw/rtl/chm_if.sv -----
// Valid/ready channel interfaces for the request and result words.
// Depends on chm_pkg for field widths.
interface chm_in_if import chm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           action;
	logic [KEY_W-1:0]     key;

	modport source (output valid, output action, output key, input ready);
	modport sink (input valid, input action, input key, output ready);
endinterface

interface chm_out_if import chm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [3:0]             status;
	logic [KEY_W-1:0]       key_out;
	logic [COUNT_OUT_W-1:0] count_out;
	logic [TOTAL_W-1:0]     live_total;
	logic [TOTAL_W-1:0]     tombstone_total;
	logic                   last;

	modport source (output valid, output status, output key_out, output count_out,
		output live_total, output tombstone_total, output last, input ready);
	modport sink (input valid, input status, input key_out, input count_out,
		input live_total, input tombstone_total, input last, output ready);
endinterface

// ----- hw/rtl/chm_hash.sv -----
// Home-slot hash: xor-shift-multiply mix on one shared 32x32 multiplier,
// then a byte-wise reduction modulo CAPACITY on the same multiplier. Depends on chm_pkg.
module chm_hash import chm_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [KEY_W-1:0]            key,
	output logic                        done,
	output logic [$clog2(CAPACITY)-1:0] slot
);
	localparam int IDXW = $clog2(CAPACITY);
	localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	// One modulo step folds the running remainder with the next key byte.
	localparam int VW = IDXW + 8;
	localparam logic [31:0] MOD_M = 32'((64'd1 << VW) / 64'(CAPACITY));

	typedef enum logic [7:0] {
		H_IDLE = 8'b0000_0001,
		H_M1L  = 8'b0000_0010,
		H_M1H  = 8'b0000_0100,
		H_M1A  = 8'b0000_1000,
		H_M2L  = 8'b0001_0000,
		H_M2H  = 8'b0010_0000,
		H_M2A  = 8'b0100_0000,
		H_MOD  = 8'b1000_0000
	} hstate_t;

	hstate_t          st_q;
	logic [63:0]      x_q, acc_q, prod_q;
	logic [2:0]       dig_q;
	logic [IDXW-1:0]  rem_q;
	logic             done_q;
	logic [IDXW-1:0]  slot_q;

	logic [31:0]      mul_a, mul_b;
	logic [63:0]      prod, sum;
	logic [VW-1:0]    mod_v, mod_q, mod_r;

	assign mod_v = {rem_q, x_q[63:56]};
	assign mul_a = (st_q == H_MOD) ? 32'(mod_v) :
		(st_q == H_M1L || st_q == H_M2L) ? x_q[31:0] : x_q[63:32];
	assign mul_b = (st_q == H_MOD) ? MOD_M :
		(st_q == H_M1L || st_q == H_M1H) ? MIX_C1 : MIX_C2;
	assign prod  = 64'(mul_a) * 64'(mul_b);
	assign sum   = acc_q + {prod_q[31:0], 32'd0};

	// The reciprocal quotient is at most one short, so one subtraction corrects it.
	assign mod_q = prod[VW +: VW];
	always_comb begin
		mod_r = mod_v - VW'(int'(mod_q) * CAPACITY);
		if (mod_r >= VW'(CAPACITY)) begin
			mod_r = mod_r - VW'(CAPACITY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				H_IDLE: if (start) st_q <= H_M1L;
				H_M1L:  st_q <= H_M1H;
				H_M1H:  st_q <= H_M1A;
				H_M1A:  st_q <= H_M2L;
				H_M2L:  st_q <= H_M2H;
				H_M2H:  st_q <= H_M2A;
				H_M2A: begin
					if (POW2) begin
						done_q <= 1'b1;
						st_q   <= H_IDLE;
					end else begin
						st_q <= H_MOD;
					end
				end
				H_MOD: begin
					if (dig_q == 3'd0) begin
						done_q <= 1'b1;
						st_q   <= H_IDLE;
					end
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: x_q <= key ^ (key >> MIX_SH1);
			H_M1L, H_M2L: prod_q <= prod;
			H_M1H, H_M2H: begin
				acc_q  <= prod_q;
				prod_q <= prod;
			end
			H_M1A: x_q <= sum ^ (sum >> MIX_SH2);
			H_M2A: begin
				x_q    <= sum ^ (sum >> MIX_SH3);
				slot_q <= IDXW'(sum ^ (sum >> MIX_SH3));
				dig_q  <= 3'd7;
				rem_q  <= '0;
			end
			H_MOD: begin
				rem_q <= mod_r[IDXW-1:0];
				x_q   <= x_q << 8;
				dig_q <= dig_q - 3'd1;
				if (dig_q == 3'd0) slot_q <= mod_r[IDXW-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign slot = slot_q;
endmodule

// ----- hw/rtl/chm_store.sv -----
// Key and count memory of the table, one write port and one registered read port.
// Depends on chm_pkg for the key width.
module chm_store import chm_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [KEY_W-1:0]            wr_key,
	input  logic [COUNT_BITS-1:0]       wr_cnt,
	output logic [KEY_W-1:0]            rd_key,
	output logic [COUNT_BITS-1:0]       rd_cnt
);
	logic [KEY_W-1:0]      key_mem [CAPACITY];
	logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			cnt_mem[wr_addr] <= wr_cnt;
		end
		rd_key <= key_mem[rd_addr];
		rd_cnt <= cnt_mem[rd_addr];
	end
endmodule

// ----- hw/rtl/counted_hash_multiset_unit.sv -----
// Top level of the counted hash multiset: sequencer, slot state and result register.
// Depends on chm_pkg, chm_if, chm_hash and chm_store.

// A fixed-capacity multiset of 64-bit keys in an open-addressed table with
// linear probing, tombstones and a count per key. Each request word is
// insert, drop, flush or none; none gives no result word, insert and drop
// give one, and flush gives one word per live key in slot order, at most 44,
// or one flush-empty word; the final word of a request carries last.
// A request is accepted while idle, then the hash runs on the shared 32x32
// multiplier, which also does the byte-wise modulo when CAPACITY is not a
// power of two; then each probed slot takes a memory read, then a compare,
// and a decide step follows when a new key is placed or refused; these wait
// while the output register holds an unaccepted word. Flush scans the slots
// and emits each live key in turn. The request port is ready only while the
// sequencer is idle; a result word waits in the output register while the
// next request is taken. A new key is refused with status full once live
// keys plus tombstones would exceed 70% of CAPACITY. There is no clearing
// pass: slot state is in flip-flops cleared by reset and by flush.
module counted_hash_multiset_unit import chm_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	chm_in_if.sink     req,
	chm_out_if.source  rsp
);
	localparam int IDXW       = $clog2(CAPACITY);
	localparam int CNTW       = $clog2(CAPACITY + 1);
	localparam int LOAD_LIMIT = (CAPACITY * 7) / 10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_INV    = 8'b0000_0010,
		S_HASH   = 8'b0000_0100,
		S_PR_RD  = 8'b0000_1000,
		S_PR_CMP = 8'b0001_0000,
		S_DECIDE = 8'b0010_0000,
		S_FL_RD  = 8'b0100_0000,
		S_FL_EM  = 8'b1000_0000
	} state_t;

	// Counts wider than the result field report their low 32 bits.
	function automatic logic [COUNT_OUT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[COUNT_OUT_W-1:0];
	endfunction

	state_t            st_q, st_d;
	slot_t             slot_st_q [CAPACITY];
	logic [CNTW-1:0]   live_q, tomb_q, live_d, tomb_d;
	logic [1:0]        act_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDXW-1:0]   idx_q, idx_d, tomb_at_q, tomb_at_d, empty_at_q, empty_at_d;
	logic              have_tomb_q, have_tomb_d, have_empty_q, have_empty_d;
	logic [CNTW-1:0]   n_q, n_d;
	logic [IDXW-1:0]   scan_q, scan_d;
	logic [CNTW-1:0]   emitted_q, emitted_d, total_q, total_d;

	// Slot state update and whole-table clear.
	logic              sw_en, clr_all;
	logic [IDXW-1:0]   sw_addr;
	slot_t             sw_val;

	// Memory write.
	logic              mw_en;
	logic [IDXW-1:0]   mw_addr;
	logic [COUNT_BITS-1:0] mw_cnt;

	// Result word to load into the output register.
	logic              emit, out_free;
	status_t           e_st;
	logic [KEY_W-1:0]  e_key;
	logic [COUNT_OUT_W-1:0] e_cnt;
	logic [CNTW-1:0]   e_live, e_tomb;
	logic              e_last;

	logic              out_valid_q;

	logic              hash_start, hash_done;
	logic [IDXW-1:0]   hash_slot, rd_addr;
	logic [KEY_W-1:0]  rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;

	logic              accept, hit, probes_done;
	logic [IDXW-1:0]   idx_next;
	slot_t             cur_st;

	chm_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	chm_store #(.CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS)) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr_en   (mw_en),
		.wr_addr (mw_addr),
		.wr_key  (key_q),
		.wr_cnt  (mw_cnt),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt)
	);

	assign req.ready   = (st_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign rd_addr     = (st_q inside {S_FL_RD, S_FL_EM}) ? scan_q : idx_q;
	assign cur_st      = slot_st_q[idx_q];
	assign hit         = (cur_st == SLOT_LIVE) && (rd_key == key_q);
	assign idx_next    = (idx_q == IDXW'(CAPACITY - 1)) ? '0 : idx_q + 1'b1;
	assign probes_done = (n_q == CNTW'(CAPACITY - 1));

	// The hash unit starts in the cycle after a request is latched.
	assign hash_start  = (st_q == S_HASH) && (n_q == '0) && !have_empty_q;

	always_comb begin
		st_d         = st_q;
		idx_d        = idx_q;
		n_d          = n_q;
		tomb_at_d    = tomb_at_q;
		empty_at_d   = empty_at_q;
		have_tomb_d  = have_tomb_q;
		have_empty_d = have_empty_q;
		scan_d       = scan_q;
		emitted_d    = emitted_q;
		total_d      = total_q;
		live_d       = live_q;
		tomb_d       = tomb_q;
		sw_en        = 1'b0;
		sw_addr      = idx_q;
		sw_val       = SLOT_LIVE;
		clr_all      = 1'b0;
		mw_en        = 1'b0;
		mw_addr      = idx_q;
		mw_cnt       = rd_cnt;
		emit         = 1'b0;
		e_st         = ST_NEW;
		e_key        = key_q;
		e_cnt        = '0;
		e_last       = 1'b1;

		case (st_q)
			S_IDLE: begin
				if (accept) begin
					if (req.action == ACT_FLUSH) begin
						scan_d    = '0;
						emitted_d = '0;
						if (int'(live_q) < MAX_RESULTS) begin
							total_d = live_q;
						end else begin
							total_d = CNTW'(MAX_RESULTS);
						end
						st_d = S_FL_RD;
					end else if (req.action == ACT_NONE) begin
						st_d = S_IDLE;
					end else if (req.key == '0) begin
						st_d = S_INV;
					end else begin
						n_d          = '0;
						have_empty_d = 1'b0;
						st_d         = S_HASH;
					end
				end
			end
			S_INV: begin
				if (out_free) begin
					emit  = 1'b1;
					e_st  = ST_INVALID;
					e_key = '0;
					st_d  = S_IDLE;
				end
			end
			S_HASH: begin
				// n_q is parked at one while the hash runs so the start fires once.
				n_d = CNTW'(1);
				if (hash_done) begin
					idx_d        = hash_slot;
					n_d          = '0;
					have_tomb_d  = 1'b0;
					have_empty_d = 1'b0;
					st_d         = S_PR_RD;
				end
			end
			S_PR_RD: st_d = S_PR_CMP;
			S_PR_CMP: begin
				if (out_free) begin
					if (act_q == ACT_INSERT) begin
						if (hit) begin
							emit  = 1'b1;
							if (rd_cnt == COUNT_MAX) begin
								e_st  = ST_SATURATED;
								e_cnt = cnt_out(rd_cnt);
							end else begin
								e_st   = ST_INCREMENTED;
								e_cnt  = cnt_out(rd_cnt + 1'b1);
								mw_en  = 1'b1;
								mw_cnt = rd_cnt + 1'b1;
							end
							st_d = S_IDLE;
						end else if (cur_st == SLOT_EMPTY) begin
							have_empty_d = 1'b1;
							empty_at_d   = idx_q;
							st_d         = S_DECIDE;
						end else begin
							if (cur_st == SLOT_TOMB && !have_tomb_q) begin
								have_tomb_d = 1'b1;
								tomb_at_d   = idx_q;
							end
							if (probes_done) begin
								st_d = S_DECIDE;
							end else begin
								idx_d = idx_next;
								n_d   = n_q + 1'b1;
								st_d  = S_PR_RD;
							end
						end
					end else begin
						if (hit) begin
							emit = 1'b1;
							if (rd_cnt > COUNT_BITS'(1)) begin
								e_st   = ST_DECREMENTED;
								e_cnt  = cnt_out(rd_cnt - 1'b1);
								mw_en  = 1'b1;
								mw_cnt = rd_cnt - 1'b1;
							end else begin
								e_st    = ST_REMOVED;
								sw_en   = 1'b1;
								sw_val  = SLOT_TOMB;
								live_d  = live_q - 1'b1;
								tomb_d  = tomb_q + 1'b1;
							end
							st_d = S_IDLE;
						end else if (cur_st == SLOT_EMPTY || probes_done) begin
							emit = 1'b1;
							e_st = ST_ABSENT;
							st_d = S_IDLE;
						end else begin
							idx_d = idx_next;
							n_d   = n_q + 1'b1;
							st_d  = S_PR_RD;
						end
					end
				end
			end
			S_DECIDE: begin
				if (out_free) begin
					emit = 1'b1;
					st_d = S_IDLE;
					if ((int'(live_q) + int'(tomb_q) + 1 > LOAD_LIMIT) ||
						(!have_tomb_q && !have_empty_q)) begin
						e_st = ST_FULL;
					end else begin
						e_st    = ST_NEW;
						e_cnt   = COUNT_OUT_W'(1);
						sw_en   = 1'b1;
						sw_val  = SLOT_LIVE;
						sw_addr = have_tomb_q ? tomb_at_q : empty_at_q;
						mw_en   = 1'b1;
						mw_addr = sw_addr;
						mw_cnt  = COUNT_BITS'(1);
						live_d  = live_q + 1'b1;
						if (have_tomb_q) tomb_d = tomb_q - 1'b1;
					end
				end
			end
			S_FL_RD: begin
				if (total_q == '0) begin
					if (out_free) begin
						emit    = 1'b1;
						e_st    = ST_FLUSH_EMPTY;
						e_key   = '0;
						clr_all = 1'b1;
						live_d  = '0;
						tomb_d  = '0;
						st_d    = S_IDLE;
					end
				end else if (slot_st_q[scan_q] == SLOT_LIVE) begin
					st_d = S_FL_EM;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			S_FL_EM: begin
				if (out_free) begin
					emit      = 1'b1;
					e_st      = ST_FLUSHED;
					e_key     = rd_key;
					e_cnt     = cnt_out(rd_cnt);
					e_last    = (emitted_q + 1'b1 == total_q);
					emitted_d = emitted_q + 1'b1;
					if (e_last) begin
						clr_all = 1'b1;
						live_d  = '0;
						tomb_d  = '0;
						st_d    = S_IDLE;
					end else begin
						scan_d = scan_q + 1'b1;
						st_d   = S_FL_RD;
					end
				end
			end
			default: st_d = S_IDLE;
		endcase

		// Totals in a result are those after the operation; flushed words report zero.
		e_live = (st_q inside {S_FL_RD, S_FL_EM}) ? '0 : live_d;
		e_tomb = (st_q inside {S_FL_RD, S_FL_EM}) ? '0 : tomb_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			live_q       <= '0;
			tomb_q       <= '0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			have_empty_q <= 1'b0;
			for (int i = 0; i < CAPACITY; i++) slot_st_q[i] <= SLOT_EMPTY;
		end else begin
			st_q         <= st_d;
			live_q       <= live_d;
			tomb_q       <= tomb_d;
			n_q          <= n_d;
			have_empty_q <= have_empty_d;
			if (clr_all) begin
				for (int i = 0; i < CAPACITY; i++) slot_st_q[i] <= SLOT_EMPTY;
			end else if (sw_en) begin
				slot_st_q[sw_addr] <= sw_val;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			key_q <= req.key;
		end
		idx_q       <= idx_d;
		tomb_at_q   <= tomb_at_d;
		empty_at_q  <= empty_at_d;
		have_tomb_q <= have_tomb_d;
		scan_q      <= scan_d;
		emitted_q   <= emitted_d;
		total_q     <= total_d;
		if (emit) begin
			rsp.status          <= e_st;
			rsp.key_out         <= e_key;
			rsp.count_out       <= e_cnt;
			rsp.live_total      <= TOTAL_W'(e_live);
			rsp.tombstone_total <= TOTAL_W'(e_tomb);
			rsp.last            <= e_last;
		end
	end

	assign rsp.valid = out_valid_q;
endmodule

// ----- hw/rtl/chm_checker.sv -----
// Port-level checks for the counted hash multiset, bound to the top level.
// Depends on chm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chm_checker import chm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [3:0]             status,
	input logic [KEY_W-1:0]       key_out,
	input logic [COUNT_OUT_W-1:0] count_out,
	input logic [TOTAL_W-1:0]     live_total,
	input logic [TOTAL_W-1:0]     tombstone_total,
	input logic                   last
);
	// A stalled result word stays offered.
	`AST_NEXT(a_hold, out_valid && !out_ready, out_valid, "result word dropped under stall")

	// Only flushed-entry words may leave last low.
	`AST_SAME(a_last, out_valid && status != ST_FLUSHED, last, "single result without last")

	// Flushed words report the totals of the emptied table.
	`AST_SAME(a_flush_tot, out_valid && (status == ST_FLUSHED || status == ST_FLUSH_EMPTY),
		live_total == '0 && tombstone_total == '0, "flush totals not zero")

	// A rejected key reports zero key and count.
	`AST_SAME(a_inv, out_valid && status == ST_INVALID, key_out == '0 && count_out == '0,
		"invalid key word carries data")

	// A newly placed key always has count one and at least one live key.
	`AST_SAME(a_new, out_valid && status == ST_NEW, count_out == 32'd1 && live_total != '0,
		"new key with wrong count or totals")
endmodule

bind counted_hash_multiset_unit chm_checker u_chm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (rsp.valid),
	.out_ready       (rsp.ready),
	.status          (rsp.status),
	.key_out         (rsp.key_out),
	.count_out       (rsp.count_out),
	.live_total      (rsp.live_total),
	.tombstone_total (rsp.tombstone_total),
	.last            (rsp.last)
);
